>>> hw/rtl/sme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable matching engine package
// Shared constants, command codes, state encoding and control bundles.
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int MAX_PAIRS_DEF = 16;
	localparam int CMD_W         = 2;
	localparam int FIELD_W       = 4;
	localparam int CFG_W         = 5;

	localparam logic [CFG_W-1:0] PAIR_COUNT_RST = 5'd16;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_PREF = 2'd0,
		CMD_LOAD_RANK = 2'd1,
		CMD_RUN       = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP,
		S_M,
		S_C,
		S_A,
		S_P,
		S_R,
		S_ERD,
		S_EWR
	} state_t;

	typedef struct packed {
		logic we;
		logic re;
		logic clr;
	} vmem_ctl_t;

	typedef struct packed {
		logic wr_en;
		logic wr_rank;
		logic pref_re;
		logic rank_re;
	} tbl_ctl_t;

endpackage

>>> hw/rtl/sme_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable matching engine channels
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface sme_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [sme_pkg::CMD_W-1:0]   command;
	logic [sme_pkg::FIELD_W-1:0] person;
	logic [sme_pkg::FIELD_W-1:0] slot;
	logic [sme_pkg::FIELD_W-1:0] entry_value;

	modport source(output valid, command, person, slot, entry_value, input ready);
	modport sink(input valid, command, person, slot, entry_value, output ready);
endinterface

interface sme_res_if;
	logic                        valid;
	logic                        ready;
	logic [sme_pkg::FIELD_W-1:0] proposer;
	logic [sme_pkg::FIELD_W-1:0] partner;
	logic                        last;

	modport source(output valid, proposer, partner, last, input ready);
	modport sink(input valid, proposer, partner, last, output ready);
endinterface

>>> hw/rtl/sme_tables.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preference and rank tables
// Two synchronous memories: proposer lists and acceptor ranks, one shared
// write port for loads and one registered read port each.
// ----------------------------------------------------------------------------
module sme_tables #(
	parameter int MAX_PAIRS = sme_pkg::MAX_PAIRS_DEF
) (
	input  logic                                      clk,
	input  sme_pkg::tbl_ctl_t                         ctl,
	input  logic [$clog2(MAX_PAIRS*MAX_PAIRS)-1:0]    waddr,
	input  logic [sme_pkg::FIELD_W-1:0]               wdata,
	input  logic [$clog2(MAX_PAIRS*MAX_PAIRS)-1:0]    pref_raddr,
	input  logic [$clog2(MAX_PAIRS*MAX_PAIRS)-1:0]    rank_raddr,
	output logic [sme_pkg::FIELD_W-1:0]               pref_rdata,
	output logic [sme_pkg::FIELD_W-1:0]               rank_rdata
);

	localparam int DEPTH = MAX_PAIRS * MAX_PAIRS;

	logic [sme_pkg::FIELD_W-1:0] pref_mem [DEPTH];
	logic [sme_pkg::FIELD_W-1:0] rank_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en && !ctl.wr_rank) begin
			pref_mem[waddr] <= wdata;
		end
		if (ctl.pref_re) begin
			pref_rdata <= pref_mem[pref_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.wr_rank) begin
			rank_mem[waddr] <= wdata;
		end
		if (ctl.rank_re) begin
			rank_rdata <= rank_mem[rank_raddr];
		end
	end

endmodule

>>> hw/rtl/sme_vmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-person state memory
// Synchronous memory with one write and one registered read port. Entries
// carry valid bits; a cleared entry reads as its reset value (a constant or
// its own index).
// ----------------------------------------------------------------------------
module sme_vmem #(
	parameter int               DEPTH     = sme_pkg::MAX_PAIRS_DEF,
	parameter int               WIDTH     = 4,
	parameter logic [WIDTH-1:0] CLR_VAL   = '0,
	parameter bit               CLR_INDEX = 1'b0
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sme_pkg::vmem_ctl_t                      ctl,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_s1;
	logic             hit_s1;
	logic [AW-1:0]    raddr_s1;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.re) begin
			rdata_s1 <= mem[raddr];
			hit_s1   <= valid_q[raddr];
			raddr_s1 <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr) begin
			valid_q <= '0;
		end else if (ctl.we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_comb begin
		if (hit_s1) begin
			rdata = rdata_s1;
		end else if (CLR_INDEX) begin
			rdata = WIDTH'(raddr_s1);
		end else begin
			rdata = CLR_VAL;
		end
	end

endmodule

>>> hw/rtl/stable_matching_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable matching engine
// Proposer-optimal stable matching over loaded preference and rank tables,
// with a FIFO of free proposers held in a per-person state memory.
// ----------------------------------------------------------------------------
//  Channel   Dir   Beat contents
//  cmd_ch    sink  command, person, slot, entry_value
//  res_ch    src   proposer, partner, last
//  cfg       in    cfg_wr_en, cfg_wr_data (pair_count)
//
// A load or an unknown command completes without leaving idle. A run clears
// the state memories, then loops over the queue, each pass a chain of
// dependent memory reads; at most about n*n proposals. Each result is emitted
// as a partner memory read, then the output load.
// State memories carry valid bits that a run start clears at once, so reset
// needs no clearing pass. A stalled result holds the emission sequencer.
// ----------------------------------------------------------------------------
module stable_matching_engine_unit #(
	parameter int MAX_PAIRS = sme_pkg::MAX_PAIRS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [sme_pkg::CFG_W-1:0] cfg_wr_data,
	sme_cmd_if.sink                   cmd_ch,
	sme_res_if.source                 res_ch
);

	localparam int PW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int NW = $clog2(MAX_PAIRS + 1);
	localparam int TW = $clog2(MAX_PAIRS * MAX_PAIRS);
	localparam logic [NW-1:0] NONE_MARK = NW'(MAX_PAIRS);

	sme_pkg::state_t state_q, state_d;

	logic [sme_pkg::CFG_W-1:0] pair_count_q;
	logic [NW-1:0]             n_q, n_cfg;
	logic [PW-1:0]             head_q;
	logic [NW-1:0]             count_q;
	logic [NW-1:0]             p_q;
	logic                      out_valid_q;

	logic [PW-1:0]             m_q, a_q, cur_q;
	logic [NW-1:0]             c_q;
	logic [sme_pkg::FIELD_W-1:0] rank_m_q;
	logic [sme_pkg::FIELD_W-1:0] proposer_q, partner_q;
	logic                      last_q;

	logic                      cmd_beat, run_beat, load_ok;
	logic                      pop, push;
	logic [NW-1:0]             c_inc, h1;
	logic [PW-1:0]             head_inc, tail;
	logic [NW:0]               tsum;

	sme_pkg::tbl_ctl_t           tbl_ctl;
	logic [TW-1:0]               tbl_waddr, pref_raddr, rank_raddr;
	logic [sme_pkg::FIELD_W-1:0] pref_rd, rank_rd;

	sme_pkg::vmem_ctl_t q_ctl, nc_ctl, par_ctl, pp_ctl;
	logic [PW-1:0]      q_waddr, q_wdata, q_raddr, q_rd;
	logic [PW-1:0]      nc_waddr, nc_raddr;
	logic [NW-1:0]      nc_wdata, nc_rd;
	logic [PW-1:0]      par_waddr, par_raddr;
	logic [NW-1:0]      par_wdata, par_rd;
	logic [PW-1:0]      pp_waddr, pp_wdata, pp_raddr, pp_rd;

	function automatic logic [TW-1:0] tbl_addr(logic [PW-1:0] row, logic [PW-1:0] col);
		return TW'(row) * TW'(MAX_PAIRS) + TW'(col);
	endfunction

	assign cmd_ch.ready   = (state_q == sme_pkg::S_IDLE);
	assign cmd_beat       = cmd_ch.valid && cmd_ch.ready;
	assign run_beat       = cmd_beat && (cmd_ch.command == sme_pkg::CMD_RUN);
	assign load_ok        = (int'(cmd_ch.person) < MAX_PAIRS) && (int'(cmd_ch.slot) < MAX_PAIRS);

	assign res_ch.valid    = out_valid_q;
	assign res_ch.proposer = proposer_q;
	assign res_ch.partner  = partner_q;
	assign res_ch.last     = last_q;

	// Zero pairs behaves as one; larger counts saturate at the table size.
	always_comb begin
		if (pair_count_q == '0) begin
			n_cfg = NW'(1);
		end else if (int'(pair_count_q) > MAX_PAIRS) begin
			n_cfg = NW'(MAX_PAIRS);
		end else begin
			n_cfg = NW'(pair_count_q);
		end
	end

	// Circular queue arithmetic modulo n; operands stay below 2n.
	assign c_inc    = c_q + NW'(1);
	assign h1       = NW'(head_q) + NW'(1);
	assign head_inc = (h1 == n_q) ? '0 : PW'(h1);
	assign tsum     = (NW+1)'(head_q) + (NW+1)'(count_q);
	assign tail     = (tsum >= (NW+1)'(n_q)) ? PW'(tsum - (NW+1)'(n_q)) : PW'(tsum);

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		push       = 1'b0;
		tbl_ctl    = '0;
		tbl_waddr  = tbl_addr(PW'(cmd_ch.person), PW'(cmd_ch.slot));
		pref_raddr = tbl_addr(m_q, PW'(c_inc));
		rank_raddr = tbl_addr(PW'(pref_rd), m_q);
		q_ctl      = '0;
		q_waddr    = tail;
		q_wdata    = cur_q;
		q_raddr    = head_q;
		nc_ctl     = '0;
		nc_waddr   = m_q;
		nc_wdata   = c_inc;
		nc_raddr   = q_rd;
		par_ctl    = '0;
		par_waddr  = a_q;
		par_wdata  = NW'(m_q);
		par_raddr  = PW'(pref_rd);
		pp_ctl     = '0;
		pp_waddr   = m_q;
		pp_wdata   = a_q;
		pp_raddr   = PW'(p_q);

		unique case (state_q)
			sme_pkg::S_IDLE: begin
				if (cmd_beat) begin
					unique case (cmd_ch.command)
						sme_pkg::CMD_LOAD_PREF: begin
							tbl_ctl.wr_en = load_ok;
						end
						sme_pkg::CMD_LOAD_RANK: begin
							tbl_ctl.wr_en   = load_ok;
							tbl_ctl.wr_rank = 1'b1;
						end
						sme_pkg::CMD_RUN: begin
							q_ctl.clr   = 1'b1;
							nc_ctl.clr  = 1'b1;
							par_ctl.clr = 1'b1;
							pp_ctl.clr  = 1'b1;
							state_d     = sme_pkg::S_POP;
						end
						default: ;
					endcase
				end
			end
			sme_pkg::S_POP: begin
				if (count_q == '0) begin
					state_d = sme_pkg::S_ERD;
				end else begin
					q_ctl.re = 1'b1;
					state_d  = sme_pkg::S_M;
				end
			end
			sme_pkg::S_M: begin
				nc_ctl.re = 1'b1;
				state_d   = sme_pkg::S_C;
			end
			sme_pkg::S_C: begin
				if (nc_rd >= n_q) begin
					// List exhausted: he leaves the queue unmatched.
					pop       = 1'b1;
					pp_ctl.we = 1'b1;
					pp_wdata  = '0;
					state_d   = sme_pkg::S_POP;
				end else begin
					tbl_ctl.pref_re = 1'b1;
					pref_raddr      = tbl_addr(m_q, PW'(nc_rd));
					state_d         = sme_pkg::S_A;
				end
			end
			sme_pkg::S_A: begin
				if (int'(pref_rd) >= int'(n_q)) begin
					nc_ctl.we = 1'b1;
					if (c_inc >= n_q) begin
						pop       = 1'b1;
						pp_ctl.we = 1'b1;
						pp_wdata  = '0;
						state_d   = sme_pkg::S_POP;
					end else begin
						tbl_ctl.pref_re = 1'b1;
						state_d         = sme_pkg::S_A;
					end
				end else begin
					par_ctl.re      = 1'b1;
					tbl_ctl.rank_re = 1'b1;
					state_d         = sme_pkg::S_P;
				end
			end
			sme_pkg::S_P: begin
				if (par_rd >= n_q) begin
					pop        = 1'b1;
					par_ctl.we = 1'b1;
					pp_ctl.we  = 1'b1;
					state_d    = sme_pkg::S_POP;
				end else begin
					tbl_ctl.rank_re = 1'b1;
					rank_raddr      = tbl_addr(a_q, PW'(par_rd));
					nc_ctl.re       = 1'b1;
					nc_raddr        = PW'(par_rd);
					state_d         = sme_pkg::S_R;
				end
			end
			sme_pkg::S_R: begin
				if (rank_m_q < rank_rd) begin
					// Trade up: the displaced partner goes to the tail and advances.
					pop        = 1'b1;
					push       = 1'b1;
					q_ctl.we   = 1'b1;
					par_ctl.we = 1'b1;
					pp_ctl.we  = 1'b1;
					nc_ctl.we  = 1'b1;
					nc_waddr   = cur_q;
					nc_wdata   = nc_rd + NW'(1);
					state_d    = sme_pkg::S_POP;
				end else begin
					nc_ctl.we = 1'b1;
					if (c_inc >= n_q) begin
						pop       = 1'b1;
						pp_ctl.we = 1'b1;
						pp_wdata  = '0;
						state_d   = sme_pkg::S_POP;
					end else begin
						tbl_ctl.pref_re = 1'b1;
						state_d         = sme_pkg::S_A;
					end
				end
			end
			sme_pkg::S_ERD: begin
				if (!out_valid_q || res_ch.ready) begin
					pp_ctl.re = 1'b1;
					state_d   = sme_pkg::S_EWR;
				end
			end
			sme_pkg::S_EWR: begin
				state_d = (p_q + NW'(1) == n_q) ? sme_pkg::S_IDLE : sme_pkg::S_ERD;
			end
			default: begin
				state_d = sme_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sme_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count_q <= sme_pkg::PAIR_COUNT_RST;
			n_q          <= NW'(MAX_PAIRS);
			head_q       <= '0;
			count_q      <= '0;
			p_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pair_count_q <= cfg_wr_data;
			end
			if (run_beat) begin
				n_q     <= n_cfg;
				head_q  <= '0;
				count_q <= n_cfg;
				p_q     <= '0;
			end
			if (pop) begin
				head_q <= head_inc;
				if (!push) begin
					count_q <= count_q - NW'(1);
				end
			end
			if (state_q == sme_pkg::S_EWR) begin
				p_q         <= p_q + NW'(1);
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sme_pkg::S_M: begin
				m_q <= q_rd;
			end
			sme_pkg::S_C: begin
				c_q <= nc_rd;
			end
			sme_pkg::S_A: begin
				if (int'(pref_rd) >= int'(n_q)) begin
					c_q <= c_inc;
				end else begin
					a_q <= PW'(pref_rd);
				end
			end
			sme_pkg::S_P: begin
				cur_q    <= PW'(par_rd);
				rank_m_q <= rank_rd;
			end
			sme_pkg::S_R: begin
				if (!(rank_m_q < rank_rd)) begin
					c_q <= c_inc;
				end
			end
			sme_pkg::S_EWR: begin
				proposer_q <= sme_pkg::FIELD_W'(p_q);
				partner_q  <= sme_pkg::FIELD_W'(pp_rd);
				last_q     <= (p_q + NW'(1) == n_q);
			end
			default: ;
		endcase
	end

	sme_tables #(
		.MAX_PAIRS(MAX_PAIRS)
	) u_tables (
		.clk       (clk),
		.ctl       (tbl_ctl),
		.waddr     (tbl_waddr),
		.wdata     (cmd_ch.entry_value),
		.pref_raddr(pref_raddr),
		.rank_raddr(rank_raddr),
		.pref_rdata(pref_rd),
		.rank_rdata(rank_rd)
	);

	// Free queue: an unwritten slot holds its own index, as after a fill.
	sme_vmem #(
		.DEPTH    (MAX_PAIRS),
		.WIDTH    (PW),
		.CLR_VAL  ('0),
		.CLR_INDEX(1'b1)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (q_ctl),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rd)
	);

	sme_vmem #(
		.DEPTH    (MAX_PAIRS),
		.WIDTH    (NW),
		.CLR_VAL  ('0),
		.CLR_INDEX(1'b0)
	) u_next_choice (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (nc_ctl),
		.waddr (nc_waddr),
		.wdata (nc_wdata),
		.raddr (nc_raddr),
		.rdata (nc_rd)
	);

	sme_vmem #(
		.DEPTH    (MAX_PAIRS),
		.WIDTH    (NW),
		.CLR_VAL  (NONE_MARK),
		.CLR_INDEX(1'b0)
	) u_acc_partner (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (par_ctl),
		.waddr (par_waddr),
		.wdata (par_wdata),
		.raddr (par_raddr),
		.rdata (par_rd)
	);

	// Each proposer's latest acceptor, or zero once his list runs out.
	sme_vmem #(
		.DEPTH    (MAX_PAIRS),
		.WIDTH    (PW),
		.CLR_VAL  ('0),
		.CLR_INDEX(1'b0)
	) u_prop_partner (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (pp_ctl),
		.waddr (pp_waddr),
		.wdata (pp_wdata),
		.raddr (pp_raddr),
		.rdata (pp_rd)
	);

endmodule

>>> hw/rtl/sme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable matching engine checker
// Port-level properties of the command and result channels.
// ----------------------------------------------------------------------------
module sme_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic [sme_pkg::CMD_W-1:0]   command,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [sme_pkg::FIELD_W-1:0] proposer,
	input logic [sme_pkg::FIELD_W-1:0] partner,
	input logic                        last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(proposer) && $stable(partner)
			&& $stable(last))
		else $error("result beat changed while stalled");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (command == sme_pkg::CMD_RUN) |=> !cmd_ready)
		else $error("command taken right after a run beat");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (command != sme_pkg::CMD_RUN) |=> cmd_ready)
		else $error("load beat did not finish in one cycle");

	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready && res_valid |-> last)
		else $error("idle with a non-final result pending");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !last |=> !cmd_ready)
		else $error("idle in the middle of a result run");

endmodule

bind stable_matching_engine_unit sme_checker u_sme_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_ch.valid),
	.cmd_ready(cmd_ch.ready),
	.command  (cmd_ch.command),
	.res_valid(res_ch.valid),
	.res_ready(res_ch.ready),
	.proposer (res_ch.proposer),
	.partner  (res_ch.partner),
	.last     (res_ch.last)
);
